/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker of the block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle rule");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle rule");

`endif

/* hw/rtl/bmg_pkg.sv */
// ----------------------------------------------------------------------------
// bmg_pkg
// Shared constants and types of the binary morphological gradient block.
// ----------------------------------------------------------------------------
package bmg_pkg;

	// Default frame limits
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 2048;

	// Field widths
	localparam int GRAY_W = 8;
	localparam int DIM_W  = 12;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 4;

	// Register reset values
	localparam logic [GRAY_W-1:0] THRESHOLD_RST = 8'd127;
	localparam logic [DIM_W-1:0]  WIDTH_RST     = 12'd640;
	localparam logic [DIM_W-1:0]  HEIGHT_RST    = 12'd480;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_WIDTH     = 2'd1;
	localparam logic [1:0] REG_HEIGHT    = 2'd2;

	// Output pixel levels
	localparam logic [GRAY_W-1:0] WHITE = 8'd255;
	localparam logic [GRAY_W-1:0] BLACK = 8'd0;

	// Output queue
	localparam int OFIFO_DEPTH = 4;
	localparam int OFIFO_PW    = $clog2(OFIFO_DEPTH);

	// Line memory word: [1] row above, [0] centre row
	localparam int LINE_W = 2;

	// Control of one request in the read-data stage
	typedef struct packed {
		logic valid;
		logic pix;       // request carries a pixel (not a flush)
		logic pel;       // binarized pixel
		logic emit;      // request sends out one result
		logic refresh;   // pixel is the next one to be sent
		logic fwd;       // take read data from the write of the previous cycle
		logic up_ok;
		logic left_ok;
		logic right_ok;
		logic below_ok;
		logic last;
	} s1_ctl_t;

	// One result item
	typedef struct packed {
		logic              frame_end;
		logic              eroded;
		logic              dilated;
		logic [GRAY_W-1:0] gradient;
	} res_t;

endpackage

/* hw/rtl/binary_morph_gradient_cross.sv */
// ----------------------------------------------------------------------------
// binary_morph_gradient_cross
// Streaming binary morphological gradient over a 3x3 cross window.
// ----------------------------------------------------------------------------
// Input stream: one 8-bit gray pixel per request in raster order (s_tdata),
// or a flush request (s_tuser = 1) that carries no pixel and pushes out the
// oldest pending result. Output stream: gradient as 255/0 on m_tdata,
// dilate and erode bits on m_tuser, m_tlast on the last pixel of a frame.
// A pixel's result leaves once the pixel one row plus one column later has
// entered (or on flushes); m_tvalid rises once that request has passed the
// stage-1 control register and the result queue. While s_tready is high one
// request is taken per clock: the line memory does one read and at most one
// write each cycle; its registered read and the result queue set that delay.
// A four-entry result queue absorbs output stalls; s_tready drops only once
// that queue may fill, so input keeps flowing while results wait.
// Reset sets threshold 127, width 640, height 480 and clears all positions;
// the line memory is not cleared and needs no warm-up pass.
// Writing frame width or height restarts the stream and drops pending
// results; write registers only while the block is idle.
// ----------------------------------------------------------------------------
module binary_morph_gradient_cross #(
	parameter int MAX_WIDTH  = bmg_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bmg_pkg::MAX_HEIGHT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Input stream
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [7:0] gray
	input  logic                       s_tuser,   // [0] flush
	// Output stream
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [7:0]                 m_tdata,   // [7:0] gradient
	output logic [1:0]                 m_tuser,   // [0] dilated_bit, [1] eroded_bit
	output logic                       m_tlast,   // frame_end
	// Configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bmg_pkg::ADDR_W-1:0] paddr,
	input  logic [bmg_pkg::DATA_W-1:0] pwdata,
	output logic [bmg_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [bmg_pkg::GRAY_W-1:0] threshold_q;
	logic [bmg_pkg::DIM_W-1:0]  frame_width_q;
	logic [bmg_pkg::DIM_W-1:0]  frame_height_q;
	logic                       cfg_wr;
	logic [1:0]                 cfg_idx;
	logic                       restart;
	logic                       accept;

	logic [CW-1:0]              rd_addr;
	logic [CW-1:0]              addr_s1;
	bmg_pkg::s1_ctl_t           ctl_s1;
	logic [bmg_pkg::LINE_W-1:0] rdata;
	logic                       we;
	logic [CW-1:0]              waddr;
	logic [bmg_pkg::LINE_W-1:0] wdata;
	logic                       res_valid;
	bmg_pkg::res_t              res;
	bmg_pkg::res_t              out_res;
	logic [bmg_pkg::OFIFO_PW:0] fifo_cnt;
	logic [bmg_pkg::OFIFO_PW:0] fifo_need;

	// Configuration writes
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[3:2];
	assign restart = cfg_wr && ((cfg_idx == bmg_pkg::REG_WIDTH)
		|| (cfg_idx == bmg_pkg::REG_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q    <= bmg_pkg::THRESHOLD_RST;
			frame_width_q  <= bmg_pkg::WIDTH_RST;
			frame_height_q <= bmg_pkg::HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				bmg_pkg::REG_THRESHOLD: begin
					threshold_q <= pwdata[bmg_pkg::GRAY_W-1:0];
				end
				bmg_pkg::REG_WIDTH: begin
					frame_width_q <= pwdata[bmg_pkg::DIM_W-1:0];
				end
				bmg_pkg::REG_HEIGHT: begin
					frame_height_q <= pwdata[bmg_pkg::DIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Register read back
	always_comb begin
		unique case (cfg_idx)
			bmg_pkg::REG_THRESHOLD: prdata = bmg_pkg::DATA_W'(threshold_q);
			bmg_pkg::REG_WIDTH:     prdata = bmg_pkg::DATA_W'(frame_width_q);
			bmg_pkg::REG_HEIGHT:    prdata = bmg_pkg::DATA_W'(frame_height_q);
			default:                prdata = '0;
		endcase
	end

	// Take a request only when the queue has room for every result in flight
	assign fifo_need = fifo_cnt + (bmg_pkg::OFIFO_PW + 1)'(ctl_s1.valid && ctl_s1.emit);
	assign s_tready  = (fifo_need <= (bmg_pkg::OFIFO_PW + 1)'(bmg_pkg::OFIFO_DEPTH - 1));
	assign accept    = s_tvalid && s_tready;

	bmg_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.restart      (restart),
		.accept       (accept),
		.flush        (s_tuser),
		.gray         (s_tdata),
		.threshold    (threshold_q),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.rd_addr      (rd_addr),
		.addr_s1      (addr_s1),
		.ctl_s1       (ctl_s1)
	);

	bmg_ram #(
		.WIDTH (bmg_pkg::LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	bmg_win #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_win (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.addr_s1   (addr_s1),
		.rdata     (rdata),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.res_valid (res_valid),
		.res       (res)
	);

	bmg_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (m_tvalid && m_tready),
		.out_valid (m_tvalid),
		.out_data  (out_res),
		.count     (fifo_cnt)
	);

	// Output fields
	assign m_tdata = out_res.gradient;
	assign m_tuser = {out_res.eroded, out_res.dilated};
	assign m_tlast = out_res.frame_end;

endmodule

/* hw/rtl/bmg_ram.sv */
// ----------------------------------------------------------------------------
// bmg_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bmg_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/bmg_ctrl.sv */
// ----------------------------------------------------------------------------
// bmg_ctrl
// Request front end: binarizes pixels, tracks input and output positions and
// the pending count, decides emission and neighbour validity, and issues the
// line memory read.
// ----------------------------------------------------------------------------
module bmg_ctrl #(
	parameter int MAX_WIDTH  = bmg_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bmg_pkg::MAX_HEIGHT_DEF,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       restart,
	input  logic                       accept,
	input  logic                       flush,
	input  logic [bmg_pkg::GRAY_W-1:0] gray,
	input  logic [bmg_pkg::GRAY_W-1:0] threshold,
	input  logic [bmg_pkg::DIM_W-1:0]  frame_width,
	input  logic [bmg_pkg::DIM_W-1:0]  frame_height,
	output logic [CW-1:0]              rd_addr,
	output logic [CW-1:0]              addr_s1,
	output bmg_pkg::s1_ctl_t           ctl_s1
);

	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int PW   = $clog2(MAX_WIDTH + 3);
	localparam int CMWW = (WW > bmg_pkg::DIM_W) ? WW : bmg_pkg::DIM_W;
	localparam int CMHW = (HW > bmg_pkg::DIM_W) ? HW : bmg_pkg::DIM_W;

	logic [PW-1:0]   pending_q;
	logic [CW-1:0]   in_col_q;
	logic [CW-1:0]   out_col_q;
	logic [RW-1:0]   out_row_q;

	logic [CMWW-1:0] fw_x;
	logic [CMHW-1:0] fh_x;
	logic [WW-1:0]   w_eff;
	logic [HW-1:0]   h_eff;
	logic [PW-1:0]   w_p;
	logic [PW-1:0]   pend_in;
	logic            pix;
	logic            emit;
	logic [WW-1:0]   icol_inc;
	logic [CW-1:0]   icol_nxt;
	logic [WW-1:0]   ocol_inc;
	logic            ocol_wrap;
	logic [CW-1:0]   ocol_nxt;
	logic [HW-1:0]   orow_inc;
	logic            orow_wrap;
	logic [RW-1:0]   orow_nxt;
	bmg_pkg::s1_ctl_t ctl_d;

	// Clamp frame size to 1..MAX
	always_comb begin
		fw_x = CMWW'(frame_width);
		fh_x = CMHW'(frame_height);
		if (fw_x == '0) begin
			w_eff = WW'(1);
		end else if (fw_x > CMWW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(fw_x);
		end
		if (fh_x == '0) begin
			h_eff = HW'(1);
		end else if (fh_x > CMHW'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(fh_x);
		end
	end

	// Position steps and emission decision
	always_comb begin
		pix     = !flush;
		w_p     = PW'(w_eff);
		pend_in = pending_q + PW'(pix);
		emit    = pix ? (pending_q > w_p) : (pending_q != '0);

		icol_inc = WW'(in_col_q) + WW'(1);
		icol_nxt = (icol_inc >= w_eff) ? '0 : CW'(icol_inc);

		ocol_inc  = WW'(out_col_q) + WW'(1);
		ocol_wrap = (ocol_inc >= w_eff);
		ocol_nxt  = ocol_wrap ? '0 : CW'(ocol_inc);

		orow_inc  = HW'(out_row_q) + HW'(1);
		orow_wrap = (orow_inc >= h_eff);
		orow_nxt  = orow_wrap ? '0 : RW'(orow_inc);

		// A pixel reads its own column; a flush reads the column right of the output
		rd_addr = pix ? in_col_q : ocol_nxt;

		ctl_d.valid    = accept;
		ctl_d.pix      = pix;
		ctl_d.pel      = (gray > threshold);
		ctl_d.emit     = emit;
		ctl_d.refresh  = pix && (pending_q == '0);
		ctl_d.fwd      = ctl_s1.valid && ctl_s1.pix && (addr_s1 == rd_addr);
		ctl_d.up_ok    = (out_row_q != '0);
		ctl_d.left_ok  = (out_col_q != '0);
		ctl_d.right_ok = !ocol_wrap && (pend_in > PW'(1));
		ctl_d.below_ok = !orow_wrap && (pend_in > w_p);
		ctl_d.last     = orow_wrap && ocol_wrap;
	end

	// Advance positions and pending count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			in_col_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (restart) begin
			pending_q <= '0;
			in_col_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			pending_q <= pend_in - PW'(emit);
			if (pix) begin
				in_col_q <= icol_nxt;
			end
			if (emit) begin
				out_col_q <= ocol_nxt;
				if (ocol_wrap) begin
					out_row_q <= orow_nxt;
				end
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_d;
		end
	end

	// Stage 1 address
	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
	end

endmodule

/* hw/rtl/bmg_win.sv */
// ----------------------------------------------------------------------------
// bmg_win
// Read-data stage: forwards the previous write, writes the line memory back,
// keeps the cross window of the next output pixel and forms the result.
// ----------------------------------------------------------------------------
module bmg_win #(
	parameter int MAX_WIDTH = bmg_pkg::MAX_WIDTH_DEF,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bmg_pkg::s1_ctl_t           ctl_s1,
	input  logic [CW-1:0]              addr_s1,
	input  logic [bmg_pkg::LINE_W-1:0] rdata,
	output logic                       we,
	output logic [CW-1:0]              waddr,
	output logic [bmg_pkg::LINE_W-1:0] wdata,
	output logic                       res_valid,
	output bmg_pkg::res_t              res
);

	logic cur_c_q;    // centre of the next output pixel
	logic cur_a_q;    // pixel above it
	logic prev_c_q;   // pixel left of it
	logic last_q;     // newest pixel taken in
	logic fwd_c_q;
	logic fwd_a_q;
	logic rd_c;
	logic rd_a;
	logic dil;
	logic ero;

	// Select forwarded or memory data
	always_comb begin
		rd_c = ctl_s1.fwd ? fwd_c_q : rdata[0];
		rd_a = ctl_s1.fwd ? fwd_a_q : rdata[1];
	end

	// Write back: shift the column up by one row
	always_comb begin
		we    = ctl_s1.valid && ctl_s1.pix;
		waddr = addr_s1;
		wdata = {rd_c, ctl_s1.pel};
	end

	// Cross window result
	always_comb begin
		dil = cur_c_q
			| (ctl_s1.up_ok    & cur_a_q)
			| (ctl_s1.left_ok  & prev_c_q)
			| (ctl_s1.right_ok & rd_c)
			| (ctl_s1.below_ok & last_q);
		ero = cur_c_q
			& ctl_s1.up_ok    & cur_a_q
			& ctl_s1.left_ok  & prev_c_q
			& ctl_s1.right_ok & rd_c
			& ctl_s1.below_ok & last_q;
		res_valid     = ctl_s1.valid && ctl_s1.emit;
		res.gradient  = (dil && !ero) ? bmg_pkg::WHITE : bmg_pkg::BLACK;
		res.dilated   = dil;
		res.eroded    = ero;
		res.frame_end = ctl_s1.last;
	end

	// Hold the window and the newest pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_c_q  <= 1'b0;
			cur_a_q  <= 1'b0;
			prev_c_q <= 1'b0;
			last_q   <= 1'b0;
		end else if (ctl_s1.valid) begin
			if (ctl_s1.pix) begin
				last_q <= ctl_s1.pel;
			end
			if (ctl_s1.emit) begin
				prev_c_q <= cur_c_q;
				cur_c_q  <= rd_c;
				cur_a_q  <= rd_a;
			end else if (ctl_s1.refresh) begin
				cur_c_q <= ctl_s1.pel;
				cur_a_q <= rd_c;
			end
		end
	end

	// Keep the last write for a read of the same column
	always_ff @(posedge clk) begin
		if (we) begin
			fwd_c_q <= ctl_s1.pel;
			fwd_a_q <= rd_c;
		end
	end

endmodule

/* hw/rtl/bmg_ofifo.sv */
// ----------------------------------------------------------------------------
// bmg_ofifo
// Small result queue in front of the output channel.
// ----------------------------------------------------------------------------
module bmg_ofifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  bmg_pkg::res_t              push_data,
	input  logic                       pop,
	output logic                       out_valid,
	output bmg_pkg::res_t              out_data,
	output logic [bmg_pkg::OFIFO_PW:0] count
);

	bmg_pkg::res_t                 entry_q [bmg_pkg::OFIFO_DEPTH];
	logic [bmg_pkg::OFIFO_PW-1:0]  wr_ptr_q;
	logic [bmg_pkg::OFIFO_PW-1:0]  rd_ptr_q;
	logic [bmg_pkg::OFIFO_PW:0]    count_q;

	assign out_valid = (count_q != '0);
	assign out_data  = entry_q[rd_ptr_q];
	assign count     = count_q;

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (bmg_pkg::OFIFO_PW + 1)'(push)
				- (bmg_pkg::OFIFO_PW + 1)'(pop);
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* hw/rtl/bmg_checker.sv */
// ----------------------------------------------------------------------------
// bmg_checker
// Port-level checks of the gradient block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [1:0] m_tuser,
	input logic       m_tlast
);

	// Gradient level follows dilate and erode
	`ASSERT_IMP(a_grad_code, clk, arst_n, m_tvalid, m_tdata == ((m_tuser[0] && !m_tuser[1]) ? bmg_pkg::WHITE : bmg_pkg::BLACK))

	// Erosion never exceeds dilation
	`ASSERT_IMP(a_erode_in_dilate, clk, arst_n, m_tvalid && m_tuser[1], m_tuser[0])

	// Input backpressure only while results are waiting
	`ASSERT_IMP(a_stall_cause, clk, arst_n, !s_tready, m_tvalid)

	// Stalled result holds
	`ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind binary_morph_gradient_cross bmg_checker u_bmg_checker (.*);
